@@ hdl/kvt_pkg.sv @@
// ============================================================================
// kvt_pkg
// Shared codes for the key/value table: commands, status codes and the
// sequencer state encoding, and the width of the entry count field.
// ============================================================================
`default_nettype none

package kvt_pkg;

    // Command codes carried by the input item
    localparam logic CMD_PUT = 1'b0;
    localparam logic CMD_GET = 1'b1;

    // Status codes carried by the result item
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Width of the entry count field of a result item
    localparam int ENTRY_COUNT_W = 7;

endpackage : kvt_pkg

`default_nettype wire

@@ hdl/kvt_ram.sv @@
// ============================================================================
// kvt_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered. Contents are undefined until written.
// ============================================================================
`default_nettype none

module kvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : kvt_ram

`default_nettype wire

@@ hdl/key_value_table.sv @@
// ============================================================================
// key_value_table
// Bounded associative table of 32-bit key/value pairs with linear search.
// ============================================================================
//
// Usage:
//   Input channel (in_valid / in_stall) carries one command item: a put of
//   lookup_key/new_value or a get of lookup_key. Output channel (out_valid /
//   out_stall) returns exactly one result item per input item, in order.
//   Keys and values live in two synchronous RAMs read in lockstep. One
//   stored key is compared per cycle, starting at entry 0 and stopping at
//   the first match or at the last valid entry.
//   Sequence: the idle state accepts the item, the scan state compares n
//   entries (0 for an empty table, up to CAPACITY) and the done state loads
//   the result into the output register. One item at a time: in_stall is
//   high from acceptance until the result has been loaded into the output
//   register.
//   A waiting result sits in the output register; while out_stall is high
//   it holds, and a finished search waits in the done state until the
//   register frees up.
//   Reset empties the table (entry count zero) at once; no clearing pass.
//
`default_nettype none

module key_value_table
    import kvt_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Input channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               command,
    input  wire logic signed [31:0] lookup_key,
    input  wire logic signed [31:0] new_value,
    // Output channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      read_value,
    output logic                    hit,
    output logic [ENTRY_COUNT_W-1:0] entry_count,
    output logic                    status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // Control state
    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] cmp_idx_reg, cmp_idx_next;
    logic          out_valid_reg, out_valid_next;

    // Item and result holding registers
    logic          cmd_reg, cmd_next;
    logic [31:0]   key_reg, key_next;
    logic [31:0]   val_reg, val_next;
    logic [31:0]   res_value_reg, res_value_next;
    logic          res_hit_reg, res_hit_next;
    logic          res_status_reg, res_status_next;

    // Output registers
    logic [31:0]              read_value_reg, read_value_next;
    logic                     hit_reg, hit_next;
    logic [ENTRY_COUNT_W-1:0] entry_count_reg, entry_count_next;
    logic                     status_reg, status_next;

    // RAM ports
    logic          key_we, val_we, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [31:0]   key_wdata, val_wdata;
    logic [31:0]   key_rdata, val_rdata;

    logic                  in_accept;
    logic                  out_free;
    logic                  key_match;
    logic                  last_entry;
    logic                  table_full;
    logic [CW+ENTRY_COUNT_W-1:0] count_ext;

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign key_match  = (key_rdata == key_reg);
    assign last_entry = ((CW'(cmp_idx_reg) + CW'(1)) == count_reg);
    assign table_full = (count_reg == CW'(CAPACITY));
    assign count_ext  = {{ENTRY_COUNT_W{1'b0}}, count_reg};

    // Key and value stores, read at the same address
    kvt_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (key_we),
        .wr_addr (wr_addr),
        .wr_data (key_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (key_rdata)
    );

    kvt_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_val_ram (
        .clk     (clk),
        .wr_en   (val_we),
        .wr_addr (wr_addr),
        .wr_data (val_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (val_rdata)
    );

    // Sequencer: accept, scan one entry per cycle, then hand off the result
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        cmp_idx_next     = cmp_idx_reg;
        cmd_next         = cmd_reg;
        key_next         = key_reg;
        val_next         = val_reg;
        res_value_next   = res_value_reg;
        res_hit_next     = res_hit_reg;
        res_status_next  = res_status_reg;
        read_value_next  = read_value_reg;
        hit_next         = hit_reg;
        entry_count_next = entry_count_reg;
        status_next      = status_reg;
        out_valid_next   = out_valid_reg && out_stall;

        key_we    = 1'b0;
        val_we    = 1'b0;
        rd_en     = 1'b0;
        wr_addr   = cmp_idx_reg;
        rd_addr   = '0;
        key_wdata = key_reg;
        val_wdata = val_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    cmd_next        = command;
                    key_next        = lookup_key;
                    val_next        = new_value;
                    res_value_next  = '0;
                    res_hit_next    = 1'b0;
                    res_status_next = STATUS_OK;
                    cmp_idx_next    = '0;
                    if (count_reg == '0)
                    begin
                        // Empty table: a put appends at entry 0, a get misses
                        if (command == CMD_PUT)
                        begin
                            key_we     = 1'b1;
                            val_we     = 1'b1;
                            wr_addr    = '0;
                            key_wdata  = lookup_key;
                            val_wdata  = new_value;
                            count_next = CW'(1);
                        end
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (key_match)
                begin
                    res_hit_next = 1'b1;
                    if (cmd_reg == CMD_GET)
                    begin
                        res_value_next = val_rdata;
                    end
                    else
                    begin
                        val_we  = 1'b1;
                        wr_addr = cmp_idx_reg;
                    end
                    state_next = ST_DONE;
                end
                else if (last_entry)
                begin
                    // Miss: a put appends when there is room
                    if (cmd_reg == CMD_PUT)
                    begin
                        if (table_full)
                        begin
                            res_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            key_we     = 1'b1;
                            val_we     = 1'b1;
                            wr_addr    = count_reg[AW-1:0];
                            count_next = count_reg + CW'(1);
                        end
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_en        = 1'b1;
                    rd_addr      = cmp_idx_reg + AW'(1);
                    cmp_idx_next = cmp_idx_reg + AW'(1);
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    read_value_next  = res_value_reg;
                    hit_next         = res_hit_reg;
                    entry_count_next = count_ext[ENTRY_COUNT_W-1:0];
                    status_next      = res_status_reg;
                    out_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cmp_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_idx_reg   <= cmp_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        key_reg         <= key_next;
        val_reg         <= val_next;
        res_value_reg   <= res_value_next;
        res_hit_reg     <= res_hit_next;
        res_status_reg  <= res_status_next;
        read_value_reg  <= read_value_next;
        hit_reg         <= hit_next;
        entry_count_reg <= entry_count_next;
        status_reg      <= status_next;
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = read_value_reg;
    assign hit         = hit_reg;
    assign entry_count = entry_count_reg;
    assign status      = status_reg;

endmodule : key_value_table

`default_nettype wire

@@ hdl/kvt_checker.sv @@
// ============================================================================
// kvt_checker
// Port-level checks for the key/value table, bound to the top level.
// ============================================================================
`default_nettype none

module kvt_checker
    import kvt_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     in_valid,
    input wire logic                     in_stall,
    input wire logic                     command,
    input wire logic signed [31:0]       lookup_key,
    input wire logic signed [31:0]       new_value,
    input wire logic                     out_valid,
    input wire logic                     out_stall,
    input wire logic signed [31:0]       read_value,
    input wire logic                     hit,
    input wire logic [ENTRY_COUNT_W-1:0] entry_count,
    input wire logic                     status
);

    // A stalled input item holds its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(command) && $stable(lookup_key)
            && $stable(new_value))
        else $error("input item changed while stalled");

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(hit)
            && $stable(entry_count) && $stable(status))
        else $error("result item changed while stalled");

    // One item at a time: the block is busy right after it takes an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted again before the result was produced");

    // A dropped put is never a hit and returns zero
    a_full_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_FULL |-> !hit && read_value == '0)
        else $error("table-full result carries a hit or a value");

    // A miss always returns zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> read_value == '0)
        else $error("miss result carries a nonzero value");

endmodule : kvt_checker

bind key_value_table kvt_checker u_kvt_checker (.*);

`default_nettype wire

@@ test/kvt_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// kvt_scoreboard
// Watches both channels of the key/value table. It keeps its own copy of the
// table, works out the result of every accepted item and compares each
// accepted result with the oldest prediction.
// ============================================================================

module kvt_scoreboard
    import kvt_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // Input channel
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic                     command,
    input  logic signed [31:0]       lookup_key,
    input  logic signed [31:0]       new_value,
    // Output channel
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic signed [31:0]       read_value,
    input  logic                     hit,
    input  logic [ENTRY_COUNT_W-1:0] entry_count,
    input  logic                     status,
    // Run control
    input  logic                     end_of_run,
    output int                       fail_count,
    output int                       pending_count
);

    typedef struct packed {
        logic signed [31:0]       read_value;
        logic                     hit;
        logic [ENTRY_COUNT_W-1:0] entry_count;
        logic                     status;
    } table_answer_t;

    // Shadow copy of the table
    logic signed [31:0] shadow_keys [CAPACITY];
    logic signed [31:0] shadow_vals [CAPACITY];
    int                 shadow_used = 0;

    table_answer_t table_answers[$];

    int  errs = 0;
    int  checked = 0;
    int  get_hits = 0;
    int  get_misses = 0;
    int  overwrites = 0;
    int  appends = 0;
    int  full_drops = 0;
    bit  end_seen = 0;

    // Apply one item to the shadow table and return its result
    function automatic table_answer_t table_apply(input logic cmd,
                                                  input logic signed [31:0] key,
                                                  input logic signed [31:0] val);
        table_answer_t ans;
        int            slot;
        ans.read_value = '0;
        ans.hit        = 1'b0;
        ans.status     = STATUS_OK;
        slot = -1;
        // first match wins; keys are unique anyway
        for (int i = 0; i < shadow_used; i++)
            if (slot < 0 && shadow_keys[i] == key)
                slot = i;
        if (cmd == CMD_GET)
        begin
            if (slot >= 0)
            begin
                ans.hit        = 1'b1;
                ans.read_value = shadow_vals[slot];
                get_hits++;
            end
            else
                get_misses++;
        end
        else if (slot >= 0)
        begin
            ans.hit           = 1'b1;
            shadow_vals[slot] = val;
            overwrites++;
        end
        else if (shadow_used < CAPACITY)
        begin
            shadow_keys[shadow_used] = key;
            shadow_vals[shadow_used] = val;
            shadow_used++;
            appends++;
        end
        else
        begin
            // new key on a full table is dropped
            ans.status = STATUS_FULL;
            full_drops++;
        end
        ans.entry_count = ENTRY_COUNT_W'(shadow_used);
        return ans;
    endfunction

    always @(posedge clk)
    begin
        table_answer_t want;
        if (rst_n)
        begin
            // predict every accepted item
            if (in_valid && !in_stall)
                table_answers.push_back(table_apply(command, lookup_key, new_value));

            // compare every accepted result against the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (table_answers.size() == 0)
                begin
                    $error("result with no item outstanding: read_value %0d hit %0d",
                           read_value, hit);
                    errs++;
                end
                else
                begin
                    want = table_answers.pop_front();
                    checked++;
                    if (read_value !== want.read_value)
                    begin
                        $error("read_value: expected %0d, got %0d", want.read_value,
                               read_value);
                        errs++;
                    end
                    if (hit !== want.hit)
                    begin
                        $error("hit: expected %0d, got %0d", want.hit, hit);
                        errs++;
                    end
                    if (entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d", want.entry_count,
                               entry_count);
                        errs++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        errs++;
                    end
                end
            end

            // leftovers and coverage summary, once
            if (end_of_run && !end_seen)
            begin
                end_seen = 1;
                if (table_answers.size() != 0)
                begin
                    $error("%0d results never arrived", table_answers.size());
                    errs += table_answers.size();
                end
                $display("checked %0d results: %0d get hits, %0d get misses, %0d overwrites",
                         checked, get_hits, get_misses, overwrites);
                $display("%0d new entries stored, %0d puts refused on a full table",
                         appends, full_drops);
            end
        end
        fail_count    <= errs;
        pending_count <= table_answers.size();
    end

endmodule

@@ test/tb_key_value_table.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_key_value_table
// Drives put and get items into the key/value table under varying sender
// and receiver idling; a scoreboard beside the block predicts every result.
// ============================================================================

module tb_key_value_table;
    import kvt_pkg::*;

    localparam int TABLE_DEPTH  = 64;
    localparam int RANDOM_ITEMS = 950;
    localparam int POOL_SIZE    = 80;
    localparam int QUIET_LIMIT  = 4000;

    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] ALL_ONE = 32'shFFFF_FFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic command = CMD_PUT;
    logic signed [31:0] lookup_key = '0;
    logic signed [31:0] new_value = '0;
    logic out_stall = 1'b0;
    logic end_of_run = 1'b0;

    logic in_stall;
    logic out_valid;
    logic signed [31:0] read_value;
    logic hit;
    logic [ENTRY_COUNT_W-1:0] entry_count;
    logic status;

    int fail_count;
    int pending_count;

    int in_idle_pct = 38;
    int out_idle_pct = 84;
    int items_sent = 0;
    int quiet_cycles = 0;

    logic signed [31:0] key_pool [POOL_SIZE];

    always #10 clk = ~clk;

    key_value_table #(.CAPACITY(TABLE_DEPTH)) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .lookup_key (lookup_key),
        .new_value  (new_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_value (read_value),
        .hit        (hit),
        .entry_count(entry_count),
        .status     (status)
    );

    kvt_scoreboard #(.CAPACITY(TABLE_DEPTH)) u_scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .lookup_key   (lookup_key),
        .new_value    (new_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_value   (read_value),
        .hit          (hit),
        .entry_count  (entry_count),
        .status       (status),
        .end_of_run   (end_of_run),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    // Receiver stalls at random
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < out_idle_pct);

    // Watchdog: cycles in which neither channel moves an item
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offer one item after a random gap and hold it until accepted
    task automatic send_item(input logic cmd, input logic signed [31:0] key,
                             input logic signed [31:0] val);
        int gap;
        int third;
        third = (RANDOM_ITEMS + 20) / 3;
        // idling phases: slow receiver, then slow sender, then full rate
        if (items_sent < third)
        begin
            in_idle_pct = 38;
            out_idle_pct <= 84;
        end
        else if (items_sent < 2 * third)
        begin
            in_idle_pct = 84;
            out_idle_pct <= 38;
        end
        else
        begin
            in_idle_pct = 0;
            out_idle_pct <= 0;
        end
        gap = 0;
        while ($urandom_range(99) < in_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        lookup_key <= key;
        new_value  <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    initial
    begin
        int pick;
        logic signed [31:0] key;

        // keys near the extremes plus random ones; more keys than slots
        key_pool[0] = '0;
        key_pool[1] = ALL_ONE;
        key_pool[2] = KEY_MIN;
        key_pool[3] = KEY_MAX;
        key_pool[4] = 32'sd1;
        key_pool[5] = 32'sh7FFF_FFFE;
        key_pool[6] = 32'shFFFF_FFFE;
        key_pool[7] = 32'sh4000_0000;
        for (int i = 8; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, extreme keys and values, single-bit key misses
        send_item(CMD_GET, '0, '0);
        send_item(CMD_PUT, '0, KEY_MAX);
        send_item(CMD_GET, '0, '0);
        send_item(CMD_PUT, KEY_MIN, KEY_MIN);
        send_item(CMD_PUT, KEY_MAX, ALL_ONE);
        send_item(CMD_PUT, ALL_ONE, '0);
        send_item(CMD_PUT, 32'sd1, 32'sd1);
        send_item(CMD_GET, KEY_MIN, '0);
        send_item(CMD_GET, KEY_MAX, ALL_ONE);
        send_item(CMD_GET, ALL_ONE, KEY_MIN);
        send_item(CMD_GET, 32'sd1, '0);
        send_item(CMD_GET, 32'sh7FFF_FFFE, '0);
        send_item(CMD_GET, 32'shFFFF_FFFE, '0);
        send_item(CMD_GET, 32'sh4000_0000, '0);
        // overwrite an existing key, then read it back
        send_item(CMD_PUT, '0, 32'sh1234_5678);
        send_item(CMD_GET, '0, ALL_ONE);
        send_item(CMD_PUT, KEY_MIN, KEY_MAX);
        send_item(CMD_GET, KEY_MIN, '0);

        // Random: mostly pool keys so hits, overwrites and a full table occur;
        // some fresh random keys as noise
        repeat (RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                key = $urandom;
            else
                key = key_pool[$urandom_range(POOL_SIZE - 1)];
            send_item($urandom_range(1) ? CMD_GET : CMD_PUT, key, $urandom);
        end
        in_valid <= 1'b0;

        // drain, then allow for a late stray result
        while (pending_count != 0)
            @(posedge clk);
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        end_of_run <= 1'b1;
        repeat (2) @(posedge clk);

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
